[rtl/tqe_pkg.sv]
// ----------------------------------------------------------------------------
// tqe_pkg: shared constants and types for the timer queue expiry unit
// Slot count, time widths, result kind codes and the field widths of the
// external ports.
// ----------------------------------------------------------------------------
package tqe_pkg;

    localparam int QUEUE_SLOTS = 16;
    localparam int TIME_BITS   = 56;

    // fixed widths of the port fields
    localparam int FTIME_W = 56;
    localparam int IVAL_W  = 32;
    localparam int ID_W    = 4;
    localparam int KIND_W  = 2;

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int CNT_W  = $clog2(QUEUE_SLOTS + 1);

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [IVAL_W-1:0]    ival_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [KIND_W-1:0]    kind_t;

    localparam time_t TIME_MAX = '1;

    localparam kind_t KIND_ADDED    = 2'd0;
    localparam kind_t KIND_EXPIRED  = 2'd1;
    localparam kind_t KIND_REJECTED = 2'd2;
    localparam kind_t KIND_SUMMARY  = 2'd3;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

endpackage

[rtl/timer_queue_expiry_unit.sv]
// ----------------------------------------------------------------------------
// timer_queue_expiry_unit: ordered timer queue with expiry
// Add requests store a timer in the lowest free slot; tick requests emit due
// timers in order of expiry then slot id, re-arm or free them, and summarize.
// ----------------------------------------------------------------------------
// Sequence: a full add is rejected at once without a scan; an accepted add
// scans every slot for the current minimum, then writes. A tick makes one
// scan of the expiry RAM read port per emitted timer (at least one), plus
// re-arm and summary scans.
// Throughput: one request at a time; busy is high until the last beat.
// Result beats show for one cycle on strobe; the receiver cannot stall.
// Reset: asynchronous, active low; empties the queue (all slots free).
// ----------------------------------------------------------------------------
module timer_queue_expiry_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    req_type,
    input  logic [tqe_pkg::FTIME_W-1:0] when_time,
    input  logic [tqe_pkg::IVAL_W-1:0]  interval_us,
    input  logic [tqe_pkg::FTIME_W-1:0] now_time,
    output logic                    strobe,
    output logic [tqe_pkg::KIND_W-1:0]  result_kind,
    output logic [tqe_pkg::ID_W-1:0]    timer_id,
    output logic                    earliest_changed,
    output logic                    next_valid,
    output logic [tqe_pkg::FTIME_W-1:0] next_expiry,
    output logic                    last
);

    import tqe_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_ADD_SCAN  = 3'd1;
    localparam logic [2:0] ST_ADD_WR    = 3'd2;
    localparam logic [2:0] ST_TICK_MARK = 3'd3;
    localparam logic [2:0] ST_TICK_SCAN = 3'd4;
    localparam logic [2:0] ST_REARM     = 3'd5;
    localparam logic [2:0] ST_SUM_SCAN  = 3'd6;

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(QUEUE_SLOTS);

    // control state
    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   pv_reg, pv_next;
    logic                   best_found_reg, best_found_next;
    logic [QUEUE_SLOTS-1:0] valid_reg, valid_next;
    logic [QUEUE_SLOTS-1:0] due_reg, due_next;
    logic [QUEUE_SLOTS-1:0] fired_reg, fired_next;
    logic                   strobe_reg, strobe_next;

    // payload
    logic                   req_reg, req_next;
    time_t                  when_reg, when_next;
    ival_t                  ival_reg, ival_next;
    time_t                  now_reg, now_next;
    slot_t                  pidx_reg, pidx_next;
    slot_t                  best_idx_reg, best_idx_next;
    time_t                  best_exp_reg, best_exp_next;
    kind_t                  kind_reg, kind_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic                   early_reg, early_next;
    logic                   nvalid_reg, nvalid_next;
    logic [FTIME_W-1:0]     nexp_reg, nexp_next;
    logic                   last_reg, last_next;

    // RAM ports
    logic                   exp_we, ival_we;
    slot_t                  exp_waddr;
    time_t                  exp_wdata;
    time_t                  exp_rdata;
    ival_t                  ival_rdata;
    slot_t                  rd_addr;

    // shared compare unit and helpers
    time_t                  cmp_a;
    logic                   cmp_lt;
    logic                   le_now;
    logic                   cand;
    logic                   scan_end;
    logic                   full;
    slot_t                  free_idx;
    logic [TIME_BITS:0]     rearm_sum;
    time_t                  rearm_time;
    logic [QUEUE_SLOTS-1:0] due_left;

    tqe_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (QUEUE_SLOTS)
    ) u_exp_ram (
        .clk   (clk),
        .we    (exp_we),
        .waddr (exp_waddr),
        .wdata (exp_wdata),
        .raddr (rd_addr),
        .rdata (exp_rdata)
    );

    tqe_ram #(
        .WIDTH (IVAL_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_ival_ram (
        .clk   (clk),
        .we    (ival_we),
        .waddr (free_idx),
        .wdata (ival_reg),
        .raddr (rd_addr),
        .rdata (ival_rdata)
    );

    // One slot index is issued per cycle; its read data comes back in the next cycle.
    assign rd_addr  = cnt_reg[SLOT_W-1:0];
    assign scan_end = (cnt_reg == CNT_END) && !pv_reg;

    // Share one comparator: the scan minimum, or the new timer in the add write.
    assign cmp_a  = (state_reg == ST_ADD_WR) ? when_reg : exp_rdata;
    assign cmp_lt = cmp_a < best_exp_reg;
    assign le_now = exp_rdata <= now_reg;

    assign full = &valid_reg;

    // Re-arm at now plus interval, saturating at the top of the time range.
    assign rearm_sum  = {1'b0, now_reg} + (TIME_BITS + 1)'(ival_rdata);
    assign rearm_time = rearm_sum[TIME_BITS] ? TIME_MAX : rearm_sum[TIME_BITS-1:0];

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = QUEUE_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        due_left               = due_reg;
        due_left[best_idx_reg] = 1'b0;
    end

    // candidate for the running minimum in each scan kind
    always_comb
    begin
        case (state_reg)
            ST_ADD_SCAN,
            ST_SUM_SCAN:  cand = valid_reg[pidx_reg];
            ST_TICK_MARK: cand = valid_reg[pidx_reg] && le_now;
            ST_TICK_SCAN: cand = due_reg[pidx_reg];
            default:      cand = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pv_next         = 1'b0;
        best_found_next = best_found_reg;
        valid_next      = valid_reg;
        due_next        = due_reg;
        fired_next      = fired_reg;
        strobe_next     = 1'b0;
        req_next        = req_reg;
        when_next       = when_reg;
        ival_next       = ival_reg;
        now_next        = now_reg;
        pidx_next       = pidx_reg;
        best_idx_next   = best_idx_reg;
        best_exp_next   = best_exp_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        early_next      = early_reg;
        nvalid_next     = nvalid_reg;
        nexp_next       = nexp_reg;
        last_next       = last_reg;
        exp_we          = 1'b0;
        exp_waddr       = free_idx;
        exp_wdata       = when_reg;
        ival_we         = 1'b0;

        // Advance the slot scan in every scanning state.
        if (state_reg != ST_IDLE && state_reg != ST_ADD_WR && cnt_reg != CNT_END)
        begin
            cnt_next  = cnt_reg + 1'b1;
            pv_next   = 1'b1;
            pidx_next = cnt_reg[SLOT_W-1:0];
        end

        // Fold the slot that just came back from the RAM into the minimum.
        if (pv_reg)
        begin
            if (state_reg == ST_TICK_MARK)
            begin
                due_next[pidx_reg]   = cand;
                fired_next[pidx_reg] = cand;
            end
            if (cand && (!best_found_reg || cmp_lt))
            begin
                best_found_next = 1'b1;
                best_idx_next   = pidx_reg;
                best_exp_next   = exp_rdata;
            end
            if (state_reg == ST_REARM && fired_reg[pidx_reg])
            begin
                if (ival_rdata != '0)
                begin
                    exp_we    = 1'b1;
                    exp_waddr = pidx_reg;
                    exp_wdata = rearm_time;
                end
                else
                begin
                    valid_next[pidx_reg] = 1'b0;
                end
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next        = req_type;
                    when_next       = TIME_BITS'(when_time);
                    ival_next       = interval_us;
                    now_next        = TIME_BITS'(now_time);
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    if (req_type == REQ_TICK)
                    begin
                        state_next = ST_TICK_MARK;
                    end
                    else if (full)
                    begin
                        // Reject at once; state stays untouched.
                        strobe_next = 1'b1;
                        kind_next   = KIND_REJECTED;
                        id_next     = '0;
                        early_next  = 1'b0;
                        nvalid_next = 1'b0;
                        nexp_next   = '0;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_ADD_SCAN;
                    end
                end
            end

            ST_ADD_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_ADD_WR;
                end
            end

            ST_ADD_WR:
            begin
                exp_we                = 1'b1;
                ival_we               = 1'b1;
                valid_next[free_idx]  = 1'b1;
                strobe_next           = 1'b1;
                kind_next             = KIND_ADDED;
                id_next               = ID_W'(free_idx);
                early_next            = !best_found_reg || cmp_lt;
                nvalid_next           = 1'b0;
                nexp_next             = '0;
                last_next             = 1'b1;
                state_next            = ST_IDLE;
            end

            ST_TICK_MARK,
            ST_TICK_SCAN:
            begin
                if (scan_end)
                begin
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    if (best_found_reg)
                    begin
                        // Emit the earliest due timer and drop it from the due set.
                        due_next    = due_left;
                        strobe_next = 1'b1;
                        kind_next   = KIND_EXPIRED;
                        id_next     = ID_W'(best_idx_reg);
                        early_next  = 1'b0;
                        nvalid_next = 1'b0;
                        nexp_next   = '0;
                        last_next   = 1'b0;
                        state_next  = (due_left != '0) ? ST_TICK_SCAN : ST_REARM;
                    end
                    else
                    begin
                        state_next = ST_REARM;
                    end
                end
            end

            ST_REARM:
            begin
                if (scan_end)
                begin
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    state_next      = ST_SUM_SCAN;
                end
            end

            ST_SUM_SCAN:
            begin
                if (scan_end)
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_SUMMARY;
                    id_next     = '0;
                    early_next  = 1'b0;
                    nvalid_next = best_found_reg;
                    nexp_next   = best_found_reg ? FTIME_W'(best_exp_reg) : '0;
                    last_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pv_reg         <= 1'b0;
            best_found_reg <= 1'b0;
            valid_reg      <= '0;
            due_reg        <= '0;
            fired_reg      <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pv_reg         <= pv_next;
            best_found_reg <= best_found_next;
            valid_reg      <= valid_next;
            due_reg        <= due_next;
            fired_reg      <= fired_next;
            strobe_reg     <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        when_reg     <= when_next;
        ival_reg     <= ival_next;
        now_reg      <= now_next;
        pidx_reg     <= pidx_next;
        best_idx_reg <= best_idx_next;
        best_exp_reg <= best_exp_next;
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        early_reg    <= early_next;
        nvalid_reg   <= nvalid_next;
        nexp_reg     <= nexp_next;
        last_reg     <= last_next;
    end

    // The request kind only steers the sequencer at accept; hold it for the beat.
    assign busy             = (state_reg != ST_IDLE) && (req_reg == REQ_ADD || req_reg == REQ_TICK);
    assign strobe           = strobe_reg;
    assign result_kind      = kind_reg;
    assign timer_id         = id_reg;
    assign earliest_changed = early_reg;
    assign next_valid       = nvalid_reg;
    assign next_expiry      = nexp_reg;
    assign last             = last_reg;

endmodule

[rtl/tqe_ram.sv]
// ----------------------------------------------------------------------------
// tqe_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
